[hw/rtl/skct_pkg.sv]
// ----------------------------------------------------------------------------
// skct_pkg: shared types and constants for the sorted key count table
// Request kinds, result status codes, queue entry type and engine states.
// ----------------------------------------------------------------------------
package skct_pkg;

  // default sizes of the table
  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  // fixed field widths and queue depth
  localparam int REQ_W     = 2;
  localparam int KEY_W     = 14;
  localparam int STATUS_W  = 3;
  localparam int OUT_CNT_W = 16;
  localparam int QDEPTH    = 2;

  // request kinds as they arrive on the input stream
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 2'd0,
    REQ_SUB  = 2'd1,
    REQ_LIST = 2'd2,
    REQ_NONE = 2'd3
  } req_e_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SAT       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  // one classified request as held in the queue
  typedef struct packed {
    req_e_t           req;
    logic [KEY_W-1:0] key;
  } cmd_t;

  // queue status towards the intake and the engine
  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_stat_t;

  // engine sequencer states
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_UPD,
    ENG_LIST
  } eng_state_t;

endpackage

[hw/rtl/skct_front.sv]
// ----------------------------------------------------------------------------
// skct_front: request intake
// Unpacks the input transaction, classifies it and pushes meaningful requests
// into the command queue; requests of no meaning are taken and dropped.
// ----------------------------------------------------------------------------
module skct_front (
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [skct_pkg::KEY_W-1:0]         in_tdata,
  input  logic [skct_pkg::REQ_W-1:0]         in_tuser,
  input  skct_pkg::q_stat_t                  q_stat_i,
  output logic                               push_o,
  output skct_pkg::cmd_t                     cmd_o
);
  import skct_pkg::*;

  req_e_t req_c;

  // field unpacking
  assign req_c = req_e_t'(in_tuser);

  // accept whenever the queue has room
  assign in_tready = q_stat_i.not_full;

  // only add, subtract and list reach the engine
  always_comb begin
    cmd_o.req = req_c;
    cmd_o.key = in_tdata;
    push_o    = 1'b0;
    unique case (req_c)
      REQ_ADD, REQ_SUB, REQ_LIST: push_o = in_tvalid & q_stat_i.not_full;
      default:                    push_o = 1'b0;
    endcase
  end

endmodule

[hw/rtl/skct_queue.sv]
// ----------------------------------------------------------------------------
// skct_queue: command queue
// Two-entry queue between intake and engine so either side can stall alone.
// ----------------------------------------------------------------------------
module skct_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  skct_pkg::cmd_t     cmd_i,
  input  logic               pop_i,
  output skct_pkg::cmd_t     head_o,
  output skct_pkg::q_stat_t  stat_o
);
  import skct_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  cmd_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign stat_o.not_empty = (fill_r != '0);
  assign stat_o.not_full  = (fill_r != (PTR_W+1)'(QDEPTH));
  assign do_push = push_i & stat_o.not_full;
  assign do_pop  = pop_i & stat_o.not_empty;
  assign head_o  = mem_r[rd_ptr_r];

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_i;
    end
  end

endmodule

[hw/rtl/skct_engine.sv]
// ----------------------------------------------------------------------------
// skct_engine: table engine
// Holds the sorted slots, compares a key against all of them at once, then
// shifts in order to insert or remove; list rotates the table through slot 0.
// ----------------------------------------------------------------------------
module skct_engine #(
  parameter int ENTRIES    = skct_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = skct_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  skct_pkg::cmd_t                    head_i,
  input  skct_pkg::q_stat_t                 q_stat_i,
  output logic                              pop_o,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [skct_pkg::STATUS_W-1:0]     out_status,
  output logic [skct_pkg::KEY_W-1:0]        out_key,
  output logic [skct_pkg::OUT_CNT_W-1:0]    out_count,
  output logic                              out_last
);
  import skct_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USE_W = $clog2(ENTRIES + 1);
  localparam int EXT_W = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // table
  logic [KEY_W-1:0]      slot_key_r [ENTRIES];
  logic [KEY_W-1:0]      slot_key_nxt [ENTRIES];
  logic [COUNT_BITS-1:0] slot_cnt_r [ENTRIES];
  logic [COUNT_BITS-1:0] slot_cnt_nxt [ENTRIES];
  logic [USE_W-1:0]      used_r, used_nxt;

  // neighbour views for shifting
  logic [KEY_W-1:0]      up_key [ENTRIES];
  logic [COUNT_BITS-1:0] up_cnt [ENTRIES];
  logic [KEY_W-1:0]      dn_key [ENTRIES];
  logic [COUNT_BITS-1:0] dn_cnt [ENTRIES];

  // sequencer and compare results
  eng_state_t            state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [ENTRIES-1:0]    lt_c, eq_c;
  logic [ENTRIES-1:0]    lt_r, lt_nxt, eq_r, eq_nxt, lt_prev;
  logic [IDX_W-1:0]      idx_r, idx_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [KEY_W-1:0]      out_key_r, out_key_nxt;
  logic [COUNT_BITS-1:0] out_cnt_r, out_cnt_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [EXT_W-1:0]      out_cnt_ext;

  // update decode
  logic                  can_emit, hit, full, sat;
  logic [COUNT_BITS-1:0] hit_cnt;

  assign can_emit   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_cnt_ext = EXT_W'(out_cnt_r);
  assign out_count  = out_cnt_ext[OUT_CNT_W-1:0];
  assign out_last   = out_last_r;

  // parallel compare of the queue head against every valid slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      lt_c[i] = (USE_W'(i) < used_r) && (slot_key_r[i] < head_i.key);
      eq_c[i] = (USE_W'(i) < used_r) && (slot_key_r[i] == head_i.key);
    end
  end

  // shifted copies; the downward view wraps round for list rotation
  always_comb begin
    up_key[0] = slot_key_r[0];
    up_cnt[0] = slot_cnt_r[0];
    for (int i = 1; i < ENTRIES; i++) begin
      up_key[i] = slot_key_r[i-1];
      up_cnt[i] = slot_cnt_r[i-1];
    end
    for (int i = 0; i < ENTRIES - 1; i++) begin
      dn_key[i] = slot_key_r[i+1];
      dn_cnt[i] = slot_cnt_r[i+1];
    end
    dn_key[ENTRIES-1] = slot_key_r[0];
    dn_cnt[ENTRIES-1] = slot_cnt_r[0];
  end

  // hit slot count picked by the one-hot match vector
  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_cnt = hit_cnt | (slot_cnt_r[i] & {COUNT_BITS{eq_r[i]}});
    end
  end

  assign hit     = |eq_r;
  assign full    = (used_r == USE_W'(ENTRIES));
  assign sat     = (hit_cnt == CNT_MAX);
  assign lt_prev = (lt_r << 1) | ENTRIES'(1);

  // sequencer: next state, table updates and result generation
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    lt_nxt         = lt_r;
    eq_nxt         = eq_r;
    idx_nxt        = idx_r;
    used_nxt       = used_r;
    slot_key_nxt   = slot_key_r;
    slot_cnt_nxt   = slot_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    pop_o          = 1'b0;

    unique case (state_r)
      ENG_IDLE: begin
        if (q_stat_i.not_empty) begin
          pop_o   = 1'b1;
          cmd_nxt = head_i;
          lt_nxt  = lt_c;
          eq_nxt  = eq_c;
          idx_nxt = '0;
          state_nxt = (head_i.req == REQ_LIST) ? ENG_LIST : ENG_UPD;
        end
      end

      ENG_UPD: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = cmd_r.key;
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_OK;
          out_cnt_nxt    = '0;
          state_nxt      = ENG_IDLE;
          if (cmd_r.req == REQ_ADD) begin
            if (hit) begin
              // bump the matching slot or report saturation
              if (sat) begin
                out_status_nxt = ST_SAT;
                out_cnt_nxt    = CNT_MAX;
              end else begin
                out_cnt_nxt = hit_cnt + CNT_ONE;
                for (int i = 0; i < ENTRIES; i++) begin
                  if (eq_r[i]) slot_cnt_nxt[i] = slot_cnt_r[i] + CNT_ONE;
                end
              end
            end else if (full) begin
              out_status_nxt = ST_FULL;
            end else begin
              // open a gap at the first slot not below the key
              out_cnt_nxt = CNT_ONE;
              used_nxt    = used_r + 1'b1;
              for (int i = 0; i < ENTRIES; i++) begin
                if (!lt_r[i]) begin
                  if (lt_prev[i]) begin
                    slot_key_nxt[i] = cmd_r.key;
                    slot_cnt_nxt[i] = CNT_ONE;
                  end else begin
                    slot_key_nxt[i] = up_key[i];
                    slot_cnt_nxt[i] = up_cnt[i];
                  end
                end
              end
            end
          end else begin
            if (!hit) begin
              out_status_nxt = ST_NOT_FOUND;
            end else if (hit_cnt == CNT_ONE) begin
              // last one gone: close the gap
              used_nxt = used_r - 1'b1;
              for (int i = 0; i < ENTRIES; i++) begin
                if (!lt_r[i]) begin
                  slot_key_nxt[i] = dn_key[i];
                  slot_cnt_nxt[i] = dn_cnt[i];
                end
              end
            end else begin
              out_cnt_nxt = hit_cnt - CNT_ONE;
              for (int i = 0; i < ENTRIES; i++) begin
                if (eq_r[i]) slot_cnt_nxt[i] = slot_cnt_r[i] - CNT_ONE;
              end
            end
          end
        end
      end

      ENG_LIST: begin
        if (can_emit) begin
          if (used_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
            out_key_nxt    = '0;
            out_cnt_nxt    = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = ENG_IDLE;
          end else begin
            // emit slot 0 while valid, rotate one full turn
            if (USE_W'(idx_r) < used_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_LISTED;
              out_key_nxt    = slot_key_r[0];
              out_cnt_nxt    = slot_cnt_r[0];
              out_last_nxt   = (USE_W'(idx_r) + 1'b1 == used_r);
            end
            for (int i = 0; i < ENTRIES; i++) begin
              slot_key_nxt[i] = dn_key[i];
              slot_cnt_nxt[i] = dn_cnt[i];
            end
            idx_nxt = idx_r + 1'b1;
            if (idx_r == IDX_W'(ENTRIES - 1)) begin
              state_nxt = ENG_IDLE;
            end
          end
        end
      end

      default: state_nxt = ENG_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers and table
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    lt_r         <= lt_nxt;
    eq_r         <= eq_nxt;
    idx_r        <= idx_nxt;
    slot_key_r   <= slot_key_nxt;
    slot_cnt_r   <= slot_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

[hw/rtl/sorted_key_count_table.sv]
// ----------------------------------------------------------------------------
// sorted_key_count_table: sorted counted key table
// Keeps up to ENTRIES distinct keys in ascending order, each with a count.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: one request per transaction: add one, subtract one or list.
//   Requests of kind 3 are taken and dropped without a result.
//   Output stream: one result per add or subtract, one per entry for list
//   (ascending key order, tlast on the final one), or one empty result when
//   the table holds nothing. tlast is high on the last result of a request.
//   Requests pass a two-entry queue into the table engine. The engine first
//   takes an add or subtract and compares the key against all slots, then
//   does the ordered shift and the result. A list rotates the whole table
//   once through slot 0, emitting each valid entry on the way; an empty
//   table gives the single empty result instead.
//   With the queue empty, a taken request is held in the queue entry, then
//   in the engine's compare registers, and its result in the result register.
//   A stalled receiver holds the result register; the engine then waits and
//   the queue fills, after which in_tready drops.
//   Reset empties the table and the queue at once; slot contents are only
//   read below the fill count, so they need no clearing.
// ----------------------------------------------------------------------------
module sorted_key_count_table #(
  parameter int ENTRIES    = skct_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = skct_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // item_key[13:0], zero
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // entry_key[13:0], entry_count[29:14], zero
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast
);
  import skct_pkg::*;

  cmd_t                 push_cmd, head_cmd;
  q_stat_t              q_stat;
  logic                 push, pop;
  logic [KEY_W-1:0]     res_key;
  logic [OUT_CNT_W-1:0] res_cnt;

  // intake and classification
  skct_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata[KEY_W-1:0]),
    .in_tuser  (in_tuser),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // command queue
  skct_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (q_stat)
  );

  // table engine
  skct_engine #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_i     (head_cmd),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .out_key    (res_key),
    .out_count  (res_cnt),
    .out_last   (out_tlast)
  );

  // result packing
  assign out_tdata = {2'b00, res_cnt, res_key};

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted key count table
// Add, subtract, list and dropped requests are streamed in while both sides idle at
// random. A behavioural copy of the sorted table predicts every result, and
// the results are checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import skct_pkg::*;

  localparam int          TBL_DEPTH = ENTRIES_DEF;
  localparam int          CNT_W     = COUNT_BITS_DEF;
  localparam logic [32:0] CNT_TOP   = (33'd1 << CNT_W) - 33'd1;
  localparam int          MAX_GAP   = 13;
  localparam int          LIMIT     = 2_000_000;
  localparam int          POOL_N    = 28;

  // one request waiting to be sent
  typedef struct {
    req_e_t           req;
    logic [KEY_W-1:0] key;
    bit               drain;  // hold until every pending result is in
    bit               calm;   // no idling on either side
  } request_t;

  // one result the table should produce
  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [KEY_W-1:0]     key;
    logic [OUT_CNT_W-1:0] count;
    logic                 last;
    bit                   calm;
  } result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // item_key[13:0], zero
  logic [1:0]  in_tuser   = '0;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // entry_key[13:0], entry_count[29:14], zero
  logic [2:0]  out_tuser;         // status[2:0]
  logic        out_tlast;

  // expected table contents
  logic [KEY_W-1:0] tbl_key [TBL_DEPTH];
  logic [32:0]      tbl_cnt [TBL_DEPTH];
  int               tbl_used = 0;

  request_t req_q[$];
  result_t  want_q[$];
  request_t tx_cur;
  int       tx_gap   = -1;
  int       rx_wait  = 0;
  int       n_queued = 0;
  int       n_taken  = 0;
  int       err_cnt  = 0;
  int       cyc      = 0;

  sorted_key_count_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // idle cycles before the next transaction on either side
  function automatic int draw_gap(bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic queue_req(req_e_t rq, logic [KEY_W-1:0] k, bit drain, bit calm);
    request_t r;
    r.req   = rq;
    r.key   = k;
    r.drain = drain;
    r.calm  = calm;
    req_q.push_back(r);
    n_queued++;
  endtask

  function automatic void push_result(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] k,
                                      logic [OUT_CNT_W-1:0] cnt, logic last, bit calm);
    result_t w;
    w.status = st;
    w.key    = k;
    w.count  = cnt;
    w.last   = last;
    w.calm   = calm;
    want_q.push_back(w);
  endfunction

  // apply one request to the table copy and queue the results it causes
  function automatic void predict_table(request_t r);
    int pos;
    int j;
    bit hit;
    pos = 0;
    if (r.req == REQ_LIST) begin
      if (tbl_used == 0) begin
        push_result(ST_EMPTY, '0, '0, 1'b1, r.calm);
      end else begin
        for (j = 0; j < tbl_used; j++)
          push_result(ST_LISTED, tbl_key[j], tbl_cnt[j][OUT_CNT_W-1:0],
                      j == tbl_used - 1, r.calm);
      end
    end else if (r.req != REQ_NONE) begin
      while (pos < tbl_used && tbl_key[pos] < r.key) pos++;
      hit = (pos < tbl_used) && (tbl_key[pos] == r.key);
      if (r.req == REQ_ADD) begin
        if (hit && tbl_cnt[pos] >= CNT_TOP) begin
          tbl_cnt[pos] = CNT_TOP;
          push_result(ST_SAT, r.key, CNT_TOP[OUT_CNT_W-1:0], 1'b1, r.calm);
        end else if (hit) begin
          tbl_cnt[pos] = tbl_cnt[pos] + 1;
          push_result(ST_OK, r.key, tbl_cnt[pos][OUT_CNT_W-1:0], 1'b1, r.calm);
        end else if (tbl_used >= TBL_DEPTH) begin
          push_result(ST_FULL, r.key, '0, 1'b1, r.calm);
        end else begin
          // ordered insert: later entries move down one slot
          for (j = tbl_used; j > pos; j--) begin
            tbl_key[j] = tbl_key[j-1];
            tbl_cnt[j] = tbl_cnt[j-1];
          end
          tbl_key[pos] = r.key;
          tbl_cnt[pos] = 33'd1;
          tbl_used++;
          push_result(ST_OK, r.key, 16'd1, 1'b1, r.calm);
        end
      end else if (!hit) begin
        push_result(ST_NOT_FOUND, r.key, '0, 1'b1, r.calm);
      end else begin
        tbl_cnt[pos] = tbl_cnt[pos] - 1;
        if (tbl_cnt[pos] == 0) begin
          // entry removed: later entries move up one slot
          for (j = pos; j + 1 < tbl_used; j++) begin
            tbl_key[j] = tbl_key[j+1];
            tbl_cnt[j] = tbl_cnt[j+1];
          end
          tbl_used--;
          push_result(ST_OK, r.key, '0, 1'b1, r.calm);
        end else begin
          push_result(ST_OK, r.key, tbl_cnt[pos][OUT_CNT_W-1:0], 1'b1, r.calm);
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= 100)
      $display("mismatch: %s at cycle %0d: got %0h, expected %0h", what, cyc, got, want);
  endtask

  // request driver
  always @(posedge clk) begin : tx_side
    logic next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      tx_gap = -1;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_table(tx_cur);
        n_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid && req_q.size() != 0 && !(req_q[0].drain && want_q.size() != 0)) begin
        if (tx_gap < 0) tx_gap = draw_gap(req_q[0].calm);
        if (tx_gap == 0) begin
          tx_cur = req_q.pop_front();
          in_tdata <= {2'b00, tx_cur.key};
          in_tuser <= tx_cur.req;
          next_valid = 1'b1;
          tx_gap = -1;
        end else begin
          tx_gap--;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : rx_side
    result_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (want_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 32'd0);
        end else begin
          w = want_q.pop_front();
          if (out_tuser !== w.status)
            report_mismatch("status", 32'(out_tuser), 32'(w.status));
          if (out_tdata[13:0] !== w.key)
            report_mismatch("entry_key", 32'(out_tdata[13:0]), 32'(w.key));
          if (out_tdata[29:14] !== w.count)
            report_mismatch("entry_count", 32'(out_tdata[29:14]), 32'(w.count));
          if (out_tlast !== w.last)
            report_mismatch("last", 32'(out_tlast), 32'(w.last));
          if (out_tdata[31:30] !== 2'b00)
            report_mismatch("padding", 32'(out_tdata[31:30]), 32'd0);
        end
        rx_wait = draw_gap(want_q.size() != 0 && want_q[0].calm);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [KEY_W-1:0] key_pool [POOL_N];
    logic [KEY_W-1:0] k;
    req_e_t           rq;
    int               seg, i, pool_n, add_w, roll;
    bit               calm;

    // empty table, absent key, ignored request kind
    queue_req(REQ_LIST, 14'd0, 0, 0);
    queue_req(REQ_SUB, 14'd0, 0, 0);
    queue_req(REQ_NONE, 14'h3FFF, 0, 0);
    // inserts at both ends, an increment, then a list
    queue_req(REQ_ADD, 14'h3FFF, 0, 0);
    queue_req(REQ_ADD, 14'd0, 0, 0);
    queue_req(REQ_ADD, 14'd9999, 0, 0);
    queue_req(REQ_ADD, 14'd0, 0, 0);
    queue_req(REQ_LIST, 14'd0, 0, 0);
    // decrement, removal, then absent again
    queue_req(REQ_SUB, 14'd0, 0, 0);
    queue_req(REQ_SUB, 14'd0, 0, 0);
    queue_req(REQ_SUB, 14'd0, 0, 0);
    // a burst of increments on one key without gaps
    for (i = 0; i < 8; i++) queue_req(REQ_ADD, 14'd9999, i == 0, 1);
    queue_req(REQ_ADD, 14'd9999, 0, 0);
    queue_req(REQ_SUB, 14'd9999, 0, 0);
    // fill the table with inserts below and above the present keys
    for (i = 0; i < TBL_DEPTH - 2; i++)
      queue_req(REQ_ADD, (i % 2) ? 14'(10000 + 400 * i) : 14'(8000 - 500 * i), 0, 0);
    queue_req(REQ_ADD, 14'd5, 0, 0);
    queue_req(REQ_ADD, 14'h3FFF, 0, 0);
    queue_req(REQ_LIST, 14'h3FFF, 0, 0);
    queue_req(REQ_SUB, 14'h3FFF, 0, 0);

    // random part: keys mostly from a shared pool so entries hit and fill up
    key_pool[0] = 14'd0;
    key_pool[1] = 14'h3FFF;
    for (i = 2; i < POOL_N; i++) key_pool[i] = 14'($urandom_range(0, 16383));
    for (seg = 0; seg < 12; seg++) begin
      calm   = ($urandom_range(0, 3) == 0);
      pool_n = $urandom_range(4, POOL_N);
      add_w  = $urandom_range(35, 70);
      for (i = 0; i < 40; i++) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) k = 14'($urandom_range(0, 16383));
        else k = key_pool[$urandom_range(0, pool_n - 1)];
        if (roll < add_w) rq = REQ_ADD;
        else if (roll < 90) rq = REQ_SUB;
        else if (roll < 97) rq = REQ_LIST;
        else rq = REQ_NONE;
        queue_req(rq, k, i == 0 && seg % 4 == 2, calm);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (n_taken < n_queued) @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
